>>> design/mlcp_pkg.sv
// ----------------------------------------------------------------------------
// mlcp_pkg
// Shared types and constants of the multi-list cache policy.
// ----------------------------------------------------------------------------
package mlcp_pkg;

  localparam int unsigned NumCfgRegs = 6;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLICY_MODE = 3'd0,
    CFG_LISTS_IN_USE = 3'd1,
    CFG_SIZE_ZERO   = 3'd2,
    CFG_SIZE_ONE    = 3'd3,
    CFG_SIZE_TWO    = 3'd4,
    CFG_SIZE_THREE  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_UPDATE,
    BK_DONE
  } bk_state_e;

endpackage

>>> design/mlcp_front.sv
// ----------------------------------------------------------------------------
// mlcp_front
// Request queue: accepts words and holds them until the back end takes one.
// ----------------------------------------------------------------------------
module mlcp_front import mlcp_pkg::*; #(
  parameter int unsigned IdW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [IdW-1:0] obj_i,
  input  logic [3:0]     rslot_i,
  output logic           req_valid_o,
  input  logic           req_take_i,
  output logic [IdW-1:0] req_obj_o,
  output logic [3:0]     req_rslot_o
);
  // two-entry queue
  logic [IdW-1:0] obj_q [2];
  logic [3:0]     rs_q  [2];
  logic [1:0]     cnt_q, cnt_d;
  logic           rd_q, wr_q;

  assign full        = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_obj_o   = obj_q[rd_q];
  assign req_rslot_o = rs_q[rd_q];

  logic do_push, do_pop;
  assign do_push = push && !full;
  assign do_pop  = req_take_i && req_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      obj_q[wr_q] <= obj_i;
      rs_q[wr_q]  <= rslot_i;
    end
  end
endmodule

>>> design/mlcp_back.sv
// ----------------------------------------------------------------------------
// mlcp_back
// Slot store, parallel search, promotion/insert writeback and result queue.
// ----------------------------------------------------------------------------
module mlcp_back import mlcp_pkg::*; #(
  parameter int unsigned NumLists = 4,
  parameter int unsigned MaxSize  = 16,
  parameter int unsigned IdW      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_take_o,
  input  logic [IdW-1:0]        req_obj_i,
  input  logic [3:0]            req_rslot_i,
  input  logic                  mode_i,
  input  logic [2:0]            lists_i,
  input  logic [3:0][4:0]       size_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  was_hit_o,
  output logic [1:0]            hit_list_o,
  output logic                  evicted_valid_o,
  output logic [IdW-1:0]        evicted_object_o
);
  localparam int unsigned LW = (NumLists > 1) ? $clog2(NumLists) : 1;
  localparam int unsigned SW = (MaxSize > 1) ? $clog2(MaxSize) : 1;
  localparam int unsigned CW = $clog2(MaxSize + 1);

  logic           vld_q [NumLists][MaxSize];
  logic [IdW-1:0] id_q  [NumLists][MaxSize];

  bk_state_e st_q, st_d;
  logic [IdW-1:0] obj_q;
  logic [3:0]     rs_q;
  logic           hit_q;
  logic [LW-1:0]  hl_q;
  logic [SW-1:0]  hs_q;

  // result register (one deep)
  logic           rv_q;
  logic           r_hit_q, r_ev_q;
  logic [1:0]     r_hl_q;
  logic [IdW-1:0] r_eo_q;

  assign empty            = !rv_q;
  assign was_hit_o        = r_hit_q;
  assign hit_list_o       = r_hl_q;
  assign evicted_valid_o  = r_ev_q;
  assign evicted_object_o = r_eo_q;

  // clamped configuration
  logic [LW:0] act;
  logic [CW-1:0] sz [NumLists];
  always_comb begin
    if (lists_i == 3'd0) act = (LW+1)'(1);
    else if (32'(lists_i) > NumLists) act = (LW+1)'(NumLists);
    else act = (LW+1)'(lists_i);
    for (int i = 0; i < NumLists; i++) begin
      int unsigned s;
      s = (i < 4) ? 32'(size_i[i]) : MaxSize;
      if (s == 0) sz[i] = CW'(1);
      else if (s > MaxSize) sz[i] = CW'(MaxSize);
      else sz[i] = CW'(s);
    end
  end

  // search: one match vector per list, first list then first slot wins
  logic           f_hit;
  logic [LW-1:0]  f_l;
  logic [SW-1:0]  f_s;
  always_comb begin
    f_hit = 1'b0;
    f_l   = '0;
    f_s   = '0;
    for (int i = NumLists-1; i >= 0; i--) begin
      for (int j = MaxSize-1; j >= 0; j--) begin
        if ((i < int'(act)) && (j < int'(sz[i])) && vld_q[i][j] &&
            (id_q[i][j] == obj_q)) begin
          f_hit = 1'b1;
          f_l   = LW'(i);
          f_s   = SW'(j);
        end
      end
    end
  end

  // update target list
  logic           promote;
  logic [LW-1:0]  tl;
  logic [CW-1:0]  tsz;
  logic [SW-1:0]  tlast, tpos;
  logic           dis_v;
  logic [IdW-1:0] dis_id;
  always_comb begin
    promote = hit_q && (32'(hl_q) + 1 < 32'(act));
    tl      = hit_q ? LW'(32'(hl_q) + 1) : '0;
    tsz     = sz[tl];
    tlast   = SW'(tsz - CW'(1));
    tpos    = (32'(rs_q) > 32'(tlast)) ? tlast : SW'(rs_q);
    if (mode_i) begin
      dis_v  = vld_q[tl][tpos];
      dis_id = id_q[tl][tpos];
    end else begin
      dis_v  = vld_q[tl][tlast];
      dis_id = id_q[tl][tlast];
    end
  end

  logic do_upd;
  assign do_upd = (st_q == BK_UPDATE) && (!hit_q || promote);

  always_comb begin
    st_d       = st_q;
    req_take_o = 1'b0;
    case (st_q)
      BK_IDLE:   if (req_valid_i && !rv_q) begin
        req_take_o = 1'b1;
        st_d = BK_SEARCH;
      end
      BK_SEARCH: st_d = BK_UPDATE;
      BK_UPDATE: st_d = BK_DONE;
      BK_DONE:   st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      rv_q <= 1'b0;
      for (int i = 0; i < NumLists; i++)
        for (int j = 0; j < MaxSize; j++) vld_q[i][j] <= 1'b0;
    end else begin
      st_q <= st_d;
      if (pop && rv_q) rv_q <= 1'b0;
      if (st_q == BK_UPDATE) rv_q <= 1'b1;
      if (do_upd) begin
        if (mode_i) vld_q[tl][tpos] <= 1'b1;
        else begin
          for (int j = MaxSize-1; j > 0; j--)
            if (j < int'(tsz)) vld_q[tl][j] <= vld_q[tl][j-1];
          vld_q[tl][0] <= 1'b1;
        end
        if (promote) vld_q[hl_q][hs_q] <= dis_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o) begin
      obj_q <= req_obj_i;
      rs_q  <= req_rslot_i;
    end
    if (st_q == BK_SEARCH) begin
      hit_q <= f_hit;
      hl_q  <= f_l;
      hs_q  <= f_s;
    end
    if (do_upd) begin
      if (mode_i) id_q[tl][tpos] <= obj_q;
      else begin
        for (int j = MaxSize-1; j > 0; j--)
          if (j < int'(tsz)) id_q[tl][j] <= id_q[tl][j-1];
        id_q[tl][0] <= obj_q;
      end
      if (promote) id_q[hl_q][hs_q] <= dis_id;
    end
    if (st_q == BK_UPDATE) begin
      r_hit_q <= hit_q;
      r_hl_q  <= hit_q ? 2'(hl_q) : 2'd0;
      r_ev_q  <= !hit_q && dis_v;
      r_eo_q  <= (!hit_q && dis_v) ? dis_id : '0;
    end
  end
endmodule

>>> design/multi_list_cache_policy.sv
// ----------------------------------------------------------------------------
// multi_list_cache_policy
// FIFO/RAND replacement over a chain of cache lists.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  request  | push / full         | object_id_i, random_slot_i
//  result   | pop / empty         | was_hit_o, hit_list_o, evicted_*_o
//  config   | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
// A request passes through the back-end states take, search over all slots,
// writeback and done, on the single shared search/update path.
// The front queue holds two words, so requests are taken while one works.
// Reset clears all slot valid bits at once; no clearing pass.
// The back end waits while the result word has not been popped.
module multi_list_cache_policy import mlcp_pkg::*; #(
  parameter int unsigned NUM_LISTS      = 4,
  parameter int unsigned MAX_LIST_SIZE  = 16,
  parameter int unsigned OBJECT_ID_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [15:0]               object_id_i,
  input  logic [3:0]                random_slot_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      was_hit_o,
  output logic [1:0]                hit_list_o,
  output logic                      evicted_valid_o,
  output logic [15:0]               evicted_object_o,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [4:0]                cfg_data_i
);
  localparam int unsigned IdW = OBJECT_ID_BITS;

  logic            mode_q;
  logic [2:0]      lists_q;
  logic [3:0][4:0] size_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      lists_q <= 3'd4;
      size_q  <= {4{5'd16}};
    end else if (cfg_valid) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_POLICY_MODE:  mode_q    <= cfg_data_i[0];
        CFG_LISTS_IN_USE: lists_q   <= cfg_data_i[2:0];
        CFG_SIZE_ZERO:    size_q[0] <= cfg_data_i;
        CFG_SIZE_ONE:     size_q[1] <= cfg_data_i;
        CFG_SIZE_TWO:     size_q[2] <= cfg_data_i;
        CFG_SIZE_THREE:   size_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic           req_valid, req_take;
  logic [IdW-1:0] req_obj;
  logic [3:0]     req_rslot;
  logic [IdW-1:0] ev_obj;

  mlcp_front #(.IdW(IdW)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .obj_i       (IdW'(object_id_i)),
    .rslot_i     (random_slot_i),
    .req_valid_o (req_valid),
    .req_take_i  (req_take),
    .req_obj_o   (req_obj),
    .req_rslot_o (req_rslot)
  );

  mlcp_back #(.NumLists(NUM_LISTS), .MaxSize(MAX_LIST_SIZE), .IdW(IdW)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i      (req_valid),
    .req_take_o       (req_take),
    .req_obj_i        (req_obj),
    .req_rslot_i      (req_rslot),
    .mode_i           (mode_q),
    .lists_i          (lists_q),
    .size_i           (size_q),
    .empty, .pop,
    .was_hit_o, .hit_list_o, .evicted_valid_o,
    .evicted_object_o (ev_obj)
  );

  assign evicted_object_o = 16'(ev_obj);
endmodule

>>> sim/multi_list_cache_policy_tb.sv
// ----------------------------------------------------------------------------
// multi_list_cache_policy_tb
// Drives object requests through several list settings and idle patterns and
// checks every result word against a behavioral model of the list chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_list_cache_policy_tb import mlcp_pkg::*;;

  localparam int unsigned NLists  = 4;
  localparam int unsigned MaxSize = 16;

  typedef struct packed {
    logic        was_hit;
    logic [1:0]  hit_list;
    logic        evicted_valid;
    logic [15:0] evicted_object;
  } lookup_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic [15:0] object_id_i = '0;
  logic [3:0]  random_slot_i = '0;
  logic        pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_POLICY_MODE;
  logic [4:0]  cfg_data_i = '0;
  logic        full, empty, cfg_ready;
  logic        was_hit_o, evicted_valid_o;
  logic [1:0]  hit_list_o;
  logic [15:0] evicted_object_o;

  // model state
  logic        mdl_rand;
  logic [2:0]  mdl_lists;
  logic [4:0]  mdl_size [NLists];
  logic        slot_vld [NLists][MaxSize];
  logic [15:0] slot_obj [NLists][MaxSize];

  lookup_t     lookups_due [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [15:0] id_pool [$];

  always #2 clk_i = ~clk_i;

  multi_list_cache_policy DUT (.*);

  function automatic int unsigned eff_size(int unsigned i);
    int unsigned s;
    s = mdl_size[i];
    if (s < 1) s = 1;
    if (s > MaxSize) s = MaxSize;
    return s;
  endfunction

  // insert into list i, displaced slot comes back through ov/oo
  function automatic void list_insert(int unsigned i, logic nv, logic [15:0] no,
                                      logic [3:0] rs, output logic ov,
                                      output logic [15:0] oo);
    int unsigned sz, p;
    sz = eff_size(i);
    if (mdl_rand) begin
      p = (rs > sz - 1) ? sz - 1 : rs;
      ov = slot_vld[i][p];
      oo = slot_obj[i][p];
      slot_vld[i][p] = nv;
      slot_obj[i][p] = no;
    end else begin
      ov = slot_vld[i][sz-1];
      oo = slot_obj[i][sz-1];
      for (int j = sz - 1; j > 0; j--) begin
        slot_vld[i][j] = slot_vld[i][j-1];
        slot_obj[i][j] = slot_obj[i][j-1];
      end
      slot_vld[i][0] = nv;
      slot_obj[i][0] = no;
    end
  endfunction

  function automatic lookup_t predict_lookup(logic [15:0] id, logic [3:0] rs);
    lookup_t r;
    int unsigned h;
    logic ov;
    logic [15:0] oo;
    r = '0;
    h = (mdl_lists < 1) ? 1 : (mdl_lists > NLists ? NLists : mdl_lists);
    for (int unsigned i = 0; i < h; i++)
      for (int unsigned j = 0; j < eff_size(i); j++)
        if (slot_vld[i][j] && slot_obj[i][j] == id) begin
          if (i + 1 < h) begin
            list_insert(i + 1, 1'b1, id, rs, ov, oo);
            slot_vld[i][j] = ov;
            slot_obj[i][j] = oo;
          end
          r.was_hit = 1'b1;
          r.hit_list = i[1:0];
          return r;
        end
    list_insert(0, 1'b1, id, rs, ov, oo);
    r.evicted_valid = ov;
    r.evicted_object = ov ? oo : 16'd0;
    return r;
  endfunction

  // push stays high after the accepting edge; the next idle cycle or drain drops it
  task automatic send_request(logic [15:0] id, logic [3:0] rs);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    object_id_i <= id;
    random_slot_i <= rs;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    lookups_due.push_back(predict_lookup(id, rs));
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_POLICY_MODE:  mdl_rand = val[0];
      CFG_LISTS_IN_USE: mdl_lists = val[2:0];
      CFG_SIZE_ZERO:    mdl_size[0] = val;
      CFG_SIZE_ONE:     mdl_size[1] = val;
      CFG_SIZE_TWO:     mdl_size[2] = val;
      CFG_SIZE_THREE:   mdl_size[3] = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    push <= 1'b0;
    while (lookups_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // mostly reuse recent ids so hits and promotions happen
  function automatic logic [15:0] pick_id();
    logic [15:0] id;
    if (id_pool.size() != 0 && $urandom_range(99) < 75)
      id = id_pool[$urandom_range(id_pool.size() - 1)];
    else begin
      id = $urandom_range(99) < 5 ? 16'(($urandom_range(1) != 0) ? 16'hFFFF : 16'h0)
                                 : 16'($urandom);
      id_pool.push_back(id);
      if (id_pool.size() > 40) void'(id_pool.pop_front());
    end
    return id;
  endfunction

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) begin
      case ((k * 4) / n)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      send_request(pick_id(), 4'($urandom));
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_directed();
    send_request(16'h0000, 4'h0);
    send_request(16'hFFFF, 4'hF);
    send_request(16'h0000, 4'h0);   // hit list 0, promote
    send_request(16'h0000, 4'h5);   // hit list 1
    send_request(16'h0000, 4'h0);   // hit list 2
    send_request(16'h0000, 4'h0);   // hit last list, no change
    for (int k = 0; k < 18; k++) send_request(16'h1000 + 16'(k), 4'($urandom));
    drain();
  endtask

  task automatic test_fifo_small();
    write_reg(CFG_LISTS_IN_USE, 5'd2);
    write_reg(CFG_SIZE_ZERO, 5'd1);
    write_reg(CFG_SIZE_ONE, 5'd3);
    run_random(200);
    drain();
  endtask

  task automatic test_rand_mode();
    write_reg(CFG_POLICY_MODE, 5'd1);
    write_reg(CFG_LISTS_IN_USE, 5'd4);
    write_reg(CFG_SIZE_ZERO, 5'd4);
    write_reg(CFG_SIZE_ONE, 5'd0);    // acts as one slot
    write_reg(CFG_SIZE_TWO, 5'd5);
    write_reg(CFG_SIZE_THREE, 5'd31); // clamps to max
    run_random(250);
    drain();
  endtask

  task automatic test_range_edges();
    write_reg(CFG_LISTS_IN_USE, 5'd0);  // acts as one list
    write_reg(CFG_SIZE_ZERO, 5'd16);
    run_random(120);
    drain();
    write_reg(CFG_POLICY_MODE, 5'd0);
    write_reg(CFG_LISTS_IN_USE, 5'd7);  // clamps to four
    write_reg(CFG_SIZE_ZERO, 5'd2);
    write_reg(CFG_SIZE_ONE, 5'd16);
    write_reg(CFG_SIZE_TWO, 5'd1);
    write_reg(CFG_SIZE_THREE, 5'd2);
    run_random(300);
    drain();
  endtask

  // result checker
  always @(posedge clk_i) begin
    lookup_t got, want;
    if (rst_ni && pop && !empty) begin
      got = '{was_hit_o, hit_list_o, evicted_valid_o, evicted_object_o};
      if (lookups_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", got);
      end else begin
        want = lookups_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
    if (rst_ni) pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    mdl_rand = 1'b0;
    mdl_lists = 3'd4;
    for (int i = 0; i < NLists; i++) begin
      mdl_size[i] = 5'd16;
      for (int j = 0; j < MaxSize; j++) begin
        slot_vld[i][j] = 1'b0;
        slot_obj[i][j] = '0;
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fifo_small();
    test_rand_mode();
    test_range_edges();
    if (errors == 0 && lookups_due.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> multi_list_cache_policy.f
design/mlcp_pkg.sv
design/mlcp_front.sv
design/mlcp_back.sv
design/multi_list_cache_policy.sv
sim/multi_list_cache_policy_tb.sv
